// ----- sv/mcsef_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsef_pkg
// Shared types and constants for the weighted power-sum checksum unit.
// ----------------------------------------------------------------------------
package mcsef_pkg;

   localparam int SUM_W   = 32;  // accumulator and syndrome width
   localparam int COUNT_W = 13;  // byte count, holds the unit length itself
   localparam int POS_W   = 12;  // zero-based error position
   localparam int DELTA_W = 9;   // signed correction amount
   localparam int CSR_IDX_W = 2;

   // Result status codes
   localparam logic [1:0] STATUS_CLEAN   = 2'd0;
   localparam logic [1:0] STATUS_LOCATED = 2'd1;
   localparam logic [1:0] STATUS_UNCORR  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_PLAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_LINEAR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_SQUARE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_CUBE   = 2'd3;

   // Reference sums of the pristine unit
   typedef struct packed {
      logic [SUM_W-1:0] plain;
      logic [SUM_W-1:0] linear;
      logic [SUM_W-1:0] square;
      logic [SUM_W-1:0] cube;
   } ref_sums_type;

   // One finished unit, handed from the front to the checker
   typedef struct packed {
      logic [SUM_W-1:0]   s0;
      logic [SUM_W-1:0]   s1;
      logic [SUM_W-1:0]   s2;
      logic [SUM_W-1:0]   s3;
      logic [COUNT_W-1:0] count;
   } syn_entry_type;

endpackage

// ----- sv/moment_checksum_single_error_fix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moment_checksum_single_error_fix_unit
// Weighted power-sum checksum over a byte stream with single-error location.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* takes one byte per request; req_last_byte closes the unit, and a
//    unit also closes on its MAX_UNIT_BYTES-th byte.
//  - rsp_* gives one result per unit: status, error position and delta.
//  - csr_* writes the four reference sums (index 0..3); write them while
//    the block is idle.
// Timing:
//  - Bytes are taken one per cycle, back to back, unless req_stall holds them.
//  - For a clean unit or a delta out of range the checker goes straight to
//    the result; otherwise the full test runs: the 32-step serial divide of
//    the checker, then the square and cube checks.
//  - Finished units wait in a two-entry queue, so the intake stalls only
//    when two units are queued behind one under check.
// Reset clears the sums, counters, queue and reference registers; nothing
// is presented until a unit ends. While rsp_stall is high the result holds,
// the checker holds its next result, and the intake runs until the queue fills.
// ----------------------------------------------------------------------------
module moment_checksum_single_error_fix_unit
   import mcsef_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [POS_W-1:0]          rsp_error_position,
   output logic signed [DELTA_W-1:0] rsp_error_delta,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [SUM_W-1:0]          csr_wdata
);

   ref_sums_type  ref_ff;
   logic          push;
   syn_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          not_empty;
   syn_entry_type head;

   // reference sum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REF_PLAIN:  ref_ff.plain  <= csr_wdata;
            CSR_REF_LINEAR: ref_ff.linear <= csr_wdata;
            CSR_REF_SQUARE: ref_ff.square <= csr_wdata;
            CSR_REF_CUBE:   ref_ff.cube   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mcsef_front #(
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .ref_sums      (ref_ff),
      .push          (push),
      .push_entry    (push_entry),
      .queue_full    (queue_full)
   );

   mcsef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   mcsef_back u_back (
      .clock              (clock),
      .reset              (reset),
      .not_empty          (not_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_error_position (rsp_error_position),
      .rsp_error_delta    (rsp_error_delta)
   );

endmodule

// ----- sv/mcsef_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsef_front
// Byte intake: keeps running powers of the byte index, forms the three
// weighted products in one stage and accumulates them in the next; at the
// end of a unit pushes the four syndromes into the queue.
// ----------------------------------------------------------------------------
module mcsef_front
   import mcsef_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  ref_sums_type       ref_sums,
   output logic               push,
   output syn_entry_type      push_entry,
   input  logic               queue_full
);

   // index powers for the next byte (cnt + 1, its square and cube)
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]   pw2_ff, pw2_in;
   logic [SUM_W-1:0]   pw3_ff, pw3_in;

   // product stage
   logic               b_valid_ff, b_valid_in;
   logic [7:0]         b_v_ff;
   logic [20:0]        b_p1_ff;
   logic [SUM_W-1:0]   b_p2_ff;
   logic [SUM_W-1:0]   b_p3_ff;
   logic               b_end_ff;
   logic [COUNT_W-1:0] b_count_ff;

   // accumulators
   logic [SUM_W-1:0]   acc0_ff, acc0_in;
   logic [SUM_W-1:0]   acc1_ff, acc1_in;
   logic [SUM_W-1:0]   acc2_ff, acc2_in;
   logic [SUM_W-1:0]   acc3_ff, acc3_in;

   logic [COUNT_W-1:0] idx;
   logic               end_a;
   logic               accept;
   logic               b_go;
   logic [SUM_W-1:0]   sum0, sum1, sum2, sum3;
   logic [20:0]        p1;
   logic [39:0]        p2_full, p3_full;
   logic [SUM_W-1:0]   idx_w;

   // handshake: hold off only while an end-of-unit request waits on the queue
   assign req_stall = b_valid_ff && b_end_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign b_go      = b_valid_ff && !(b_end_ff && queue_full);

   assign idx   = cnt_ff + COUNT_W'(1);
   assign idx_w = SUM_W'(idx);
   assign end_a = req_last_byte || (idx == COUNT_W'(MAX_UNIT_BYTES));

   // weighted products, one multiplier each
   assign p1      = 21'(req_data_byte * idx);
   assign p2_full = req_data_byte * pw2_ff;
   assign p3_full = req_data_byte * pw3_ff;

   // index powers step forward: (i+1)^2 and (i+1)^3 by differences
   always_comb begin
      cnt_in = cnt_ff;
      pw2_in = pw2_ff;
      pw3_in = pw3_ff;
      if (accept) begin
         if (end_a) begin
            cnt_in = '0;
            pw2_in = SUM_W'(1);
            pw3_in = SUM_W'(1);
         end else begin
            cnt_in = idx;
            pw2_in = pw2_ff + (idx_w << 1) + SUM_W'(1);
            pw3_in = pw3_ff + (pw2_ff << 1) + pw2_ff + (idx_w << 1) + idx_w + SUM_W'(1);
         end
      end
   end

   // accumulate and form syndromes
   assign sum0 = acc0_ff + SUM_W'(b_v_ff);
   assign sum1 = acc1_ff + SUM_W'(b_p1_ff);
   assign sum2 = acc2_ff + b_p2_ff;
   assign sum3 = acc3_ff + b_p3_ff;

   always_comb begin
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      acc3_in = acc3_ff;
      if (b_go) begin
         if (b_end_ff) begin
            acc0_in = '0;
            acc1_in = '0;
            acc2_in = '0;
            acc3_in = '0;
         end else begin
            acc0_in = sum0;
            acc1_in = sum1;
            acc2_in = sum2;
            acc3_in = sum3;
         end
      end
   end

   assign push             = b_go && b_end_ff;
   assign push_entry.s0    = sum0 - ref_sums.plain;
   assign push_entry.s1    = sum1 - ref_sums.linear;
   assign push_entry.s2    = sum2 - ref_sums.square;
   assign push_entry.s3    = sum3 - ref_sums.cube;
   assign push_entry.count = b_count_ff;

   // product stage occupancy
   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         pw2_ff     <= SUM_W'(1);
         pw3_ff     <= SUM_W'(1);
         b_valid_ff <= 1'b0;
         acc0_ff    <= '0;
         acc1_ff    <= '0;
         acc2_ff    <= '0;
         acc3_ff    <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         pw2_ff     <= pw2_in;
         pw3_ff     <= pw3_in;
         b_valid_ff <= b_valid_in;
         acc0_ff    <= acc0_in;
         acc1_ff    <= acc1_in;
         acc2_ff    <= acc2_in;
         acc3_ff    <= acc3_in;
      end
   end

   // product stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_v_ff     <= req_data_byte;
         b_p1_ff    <= p1;
         b_p2_ff    <= p2_full[SUM_W-1:0];
         b_p3_ff    <= p3_full[SUM_W-1:0];
         b_end_ff   <= end_a;
         b_count_ff <= idx;
      end
   end

endmodule

// ----- sv/mcsef_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsef_queue
// Two-entry queue of finished units between the byte intake and the checker.
// ----------------------------------------------------------------------------
module mcsef_queue
   import mcsef_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  syn_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output syn_entry_type head
);

   syn_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/mcsef_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsef_back
// Syndrome checker: classifies a finished unit, runs a bit-serial divide of
// the linear syndrome by the delta, then checks the square and cube terms
// over registered multiply steps and presents the result.
// ----------------------------------------------------------------------------
module mcsef_back
   import mcsef_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      not_empty,
   input  syn_entry_type             head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [POS_W-1:0]          rsp_error_position,
   output logic signed [DELTA_W-1:0] rsp_error_delta
);

   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int SQ_W      = 34;   // holds d*q*q for any q up to the unit length

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DIVIDE = 7'b0000010,
      S_SQUARE = 7'b0000100,
      S_SCALE  = 7'b0001000,
      S_CUBE   = 7'b0010000,
      S_VERIFY = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // working registers
   logic [SUM_W-1:0]          s2_ff, s2_in;
   logic [SUM_W-1:0]          s3_ff, s3_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [DELTA_W-1:0] d_ff, d_in;
   logic [7:0]                dsr_ff, dsr_in;
   logic [SUM_W-1:0]          dvd_ff, dvd_in;
   logic [7:0]                rem_ff, rem_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      sign_ok_ff, sign_ok_in;
   logic [COUNT_W-1:0]        q_ff, q_in;
   logic [2*COUNT_W-1:0]      qq_ff, qq_in;
   logic signed [SQ_W-1:0]    sq_ff, sq_in;
   logic                      sq_ok_ff, sq_ok_in;
   logic [SUM_W-1:0]          cube_ff, cube_in;

   // result staging and output register
   logic [1:0]                res_status_ff, res_status_in;
   logic [POS_W-1:0]          res_pos_ff, res_pos_in;
   logic signed [DELTA_W-1:0] res_delta_ff, res_delta_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic signed [DELTA_W-1:0] rsp_delta_ff;

   logic       all_zero;
   logic       d_ok;
   logic [8:0] trial;
   logic       fits;
   logic [7:0] rem_next;
   logic [SUM_W-1:0] quo_next;
   logic       div_pass;
   logic       out_free;
   logic [SUM_W-1:0] abs_s1;
   logic [7:0] abs_d;
   logic signed [2*COUNT_W:0] qq_signed;
   logic signed [2*COUNT_W+DELTA_W:0] sq_full;
   logic [SUM_W+COUNT_W-1:0] cube_full;
   logic signed [SQ_W-1:0] s2_ext;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && not_empty;

   // classify the popped unit
   assign all_zero = (head.s0 == '0) && (head.s1 == '0) && (head.s2 == '0) && (head.s3 == '0);
   assign d_ok     = (head.s0[7:0] != 8'd0) &&
                     ((head.s0[SUM_W-1:8] == '0) || (head.s0[SUM_W-1:8] == '1));
   assign abs_s1   = head.s1[SUM_W-1] ? (~head.s1 + SUM_W'(1)) : head.s1;
   assign abs_d    = head.s0[SUM_W-1] ? (~head.s0[7:0] + 8'd1) : head.s0[7:0];

   // one restoring divide step
   assign trial    = {rem_ff, dvd_ff[SUM_W-1]};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign rem_next = fits ? 8'(trial - {1'b0, dsr_ff}) : trial[7:0];
   assign quo_next = {dvd_ff[SUM_W-2:0], fits};
   assign div_pass = (rem_next == 8'd0) && sign_ok_ff && (quo_next != '0) &&
                     (quo_next <= SUM_W'(count_ff));

   // multiply steps
   assign qq_signed = signed'({1'b0, qq_ff});
   assign sq_full   = d_ff * qq_signed;
   assign cube_full = sq_ff[SUM_W-1:0] * q_ff;
   assign s2_ext    = SQ_W'(signed'(s2_ff));

   always_comb begin
      state_in      = state_ff;
      s2_in         = s2_ff;
      s3_in         = s3_ff;
      count_in      = count_ff;
      d_in          = d_ff;
      dsr_in        = dsr_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      sign_ok_in    = sign_ok_ff;
      q_in          = q_ff;
      qq_in         = qq_ff;
      sq_in         = sq_ff;
      sq_ok_in      = sq_ok_ff;
      cube_in       = cube_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_delta_in  = res_delta_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (not_empty) begin
               s2_in         = head.s2;
               s3_in         = head.s3;
               count_in      = head.count;
               d_in          = signed'(head.s0[DELTA_W-1:0]);
               dsr_in        = abs_d;
               dvd_in        = abs_s1;
               rem_in        = 8'd0;
               step_in       = '0;
               sign_ok_in    = (head.s1[SUM_W-1] == head.s0[SUM_W-1]);
               res_pos_in    = '0;
               res_delta_in  = '0;
               if (all_zero) begin
                  res_status_in = STATUS_CLEAN;
                  state_in      = S_FINISH;
               end else if (!d_ok) begin
                  res_status_in = STATUS_UNCORR;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            dvd_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               q_in = quo_next[COUNT_W-1:0];
               if (div_pass) begin
                  state_in = S_SQUARE;
               end else begin
                  res_status_in = STATUS_UNCORR;
                  state_in      = S_FINISH;
               end
            end
         end
         S_SQUARE: begin
            qq_in    = q_ff * q_ff;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            sq_in    = SQ_W'(sq_full);
            state_in = S_CUBE;
         end
         S_CUBE: begin
            cube_in  = cube_full[SUM_W-1:0];
            sq_ok_in = (sq_ff == s2_ext);
            state_in = S_VERIFY;
         end
         S_VERIFY: begin
            if (sq_ok_ff && (cube_ff == s3_ff)) begin
               res_status_in = STATUS_LOCATED;
               res_pos_in    = POS_W'(q_ff - COUNT_W'(1));
               res_delta_in  = d_ff;
            end else begin
               res_status_in = STATUS_UNCORR;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      s2_ff         <= s2_in;
      s3_ff         <= s3_in;
      count_ff      <= count_in;
      d_ff          <= d_in;
      dsr_ff        <= dsr_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      sign_ok_ff    <= sign_ok_in;
      q_ff          <= q_in;
      qq_ff         <= qq_in;
      sq_ff         <= sq_in;
      sq_ok_ff      <= sq_ok_in;
      cube_ff       <= cube_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_delta_ff  <= res_delta_in;
   end

   // output register, loaded as the result is presented
   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_delta_ff  <= res_delta_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_error_position = rsp_pos_ff;
   assign rsp_error_delta    = rsp_delta_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted power-sum checksum fix unit.
// ----------------------------------------------------------------------------
// Streams byte units through the request port and checks every fix report
// against an in-bench predictor of the four running sums and the single-error
// search. A short directed list covers clean units, both delta extremes and
// each way the error search can reject a unit. Random phases then program the
// reference sums of a random pristine unit and send clean, singly corrupted,
// doubly corrupted, truncated, extended and noise variants of it back to back.
// Both sides idle in short random bursts except in quiet phases and near the
// end.
// ----------------------------------------------------------------------------
module tb_top;
   import mcsef_pkg::*;

   localparam int MAX_BYTES     = 4096;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 600000;

   // One fix report, as the block presents it
   typedef struct packed {
      logic [1:0]                status;
      logic [POS_W-1:0]          position;
      logic signed [DELTA_W-1:0] delta;
   } fix_report_type;

   // Predicts the fix report of every closed unit and checks the block's ones
   class fix_report_scoreboard;
      logic [SUM_W-1:0]   ref_sum [4];
      logic [COUNT_W-1:0] unit_count;
      logic [SUM_W-1:0]   acc_plain, acc_linear, acc_square, acc_cube;
      fix_report_type     pending_reports[$];
      int bytes_taken, reports_checked, mismatch_count;
      int status_seen [4];

      function new();
         foreach (ref_sum[i]) ref_sum[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         unit_count = '0;
         acc_plain = '0;
         acc_linear = '0;
         acc_square = '0;
         acc_cube = '0;
         bytes_taken = 0;
         reports_checked = 0;
         mismatch_count = 0;
      endfunction

      function void set_ref(logic [CSR_IDX_W-1:0] index, logic [SUM_W-1:0] value);
         ref_sum[index] = value;
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      // Accepted request: update the sums, and close the unit where due
      function void take_byte(logic [7:0] data, logic last);
         logic [SUM_W-1:0] term, weight, s0, s1, s2, s3;
         longint d, m1, q, sq, cu;
         fix_report_type rep;
         bytes_taken++;
         unit_count = unit_count + 1'b1;
         weight = {{(SUM_W-COUNT_W){1'b0}}, unit_count};
         term = {{(SUM_W-8){1'b0}}, data};
         acc_plain = acc_plain + term;
         term = term * weight;
         acc_linear = acc_linear + term;
         term = term * weight;
         acc_square = acc_square + term;
         term = term * weight;
         acc_cube = acc_cube + term;
         if (!last && unit_count < MAX_BYTES)
            return;

         s0 = acc_plain - ref_sum[CSR_REF_PLAIN];
         s1 = acc_linear - ref_sum[CSR_REF_LINEAR];
         s2 = acc_square - ref_sum[CSR_REF_SQUARE];
         s3 = acc_cube - ref_sum[CSR_REF_CUBE];
         rep = '{status: STATUS_UNCORR, position: '0, delta: '0};
         if ((s0 | s1 | s2 | s3) == '0) begin
            rep.status = STATUS_CLEAN;
         end else begin
            // single-error search: delta from s0, position from s1 / delta,
            // then confirm with the square and cube syndromes
            d = $signed(s0);
            m1 = $signed(s1);
            if (d >= -255 && d <= 255 && d != 0 && (m1 % d) == 0) begin
               q = m1 / d;
               sq = d * q * q;
               cu = sq * q;
               if (q >= 1 && q <= longint'(unit_count) && sq == longint'($signed(s2))
                   && cu[SUM_W-1:0] == s3) begin
                  rep.status = STATUS_LOCATED;
                  rep.position = POS_W'(q - 1);
                  rep.delta = DELTA_W'(d);
               end
            end
         end
         pending_reports.push_back(rep);
         unit_count = '0;
         acc_plain = '0;
         acc_linear = '0;
         acc_square = '0;
         acc_cube = '0;
      endfunction

      // Accepted result: compare with the oldest predicted report
      function void check_report(logic [1:0] status, logic [POS_W-1:0] position,
                                 logic signed [DELTA_W-1:0] delta);
         fix_report_type want;
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] unexpected report: status %0d pos %0d delta %0d",
                        $realtime, status, position, delta);
            return;
         end
         want = pending_reports.pop_front();
         reports_checked++;
         status_seen[want.status]++;
         if (status !== want.status || position !== want.position
             || delta !== want.delta) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] report mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        $realtime, want.status, want.position, want.delta,
                        status, position, delta);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_data_byte;
   logic                      req_last_byte;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic [POS_W-1:0]          rsp_error_position;
   logic signed [DELTA_W-1:0] rsp_error_delta;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [SUM_W-1:0]          csr_wdata;

   fix_report_scoreboard sb;
   bit               idle_enable = 1'b1;
   int               stall_left = 0;
   int               cycle_count = 0;
   int               units_sent = 0;
   logic [7:0]       pristine[$];
   logic [7:0]       unit_bytes[$];
   logic [SUM_W-1:0] ref_goal [4];

   moment_checksum_single_error_fix_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_error_position (rsp_error_position),
      .rsp_error_delta    (rsp_error_delta),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: check accepted reports, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_report(rsp_status, rsp_error_position, rsp_error_delta);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Byte value biased toward the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Reference sums of the pristine unit
   function automatic void load_ref_goal();
      logic [SUM_W-1:0] term;
      foreach (ref_goal[k]) ref_goal[k] = '0;
      foreach (pristine[i]) begin
         term = {{(SUM_W-8){1'b0}}, pristine[i]};
         ref_goal[CSR_REF_PLAIN] += term;
         term = term * (i + 1);
         ref_goal[CSR_REF_LINEAR] += term;
         term = term * (i + 1);
         ref_goal[CSR_REF_SQUARE] += term;
         term = term * (i + 1);
         ref_goal[CSR_REF_CUBE] += term;
      end
   endfunction

   // Drop valid, let every report come back, then let the checker drain
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program all four reference sums, one per cycle
   task automatic write_refs();
      csr_write <= 1'b1;
      csr_index <= CSR_REF_PLAIN;
      csr_wdata <= ref_goal[CSR_REF_PLAIN];
      sb.set_ref(CSR_REF_PLAIN, ref_goal[CSR_REF_PLAIN]);
      @(posedge clock);
      csr_index <= CSR_REF_LINEAR;
      csr_wdata <= ref_goal[CSR_REF_LINEAR];
      sb.set_ref(CSR_REF_LINEAR, ref_goal[CSR_REF_LINEAR]);
      @(posedge clock);
      csr_index <= CSR_REF_SQUARE;
      csr_wdata <= ref_goal[CSR_REF_SQUARE];
      sb.set_ref(CSR_REF_SQUARE, ref_goal[CSR_REF_SQUARE]);
      @(posedge clock);
      csr_index <= CSR_REF_CUBE;
      csr_wdata <= ref_goal[CSR_REF_CUBE];
      sb.set_ref(CSR_REF_CUBE, ref_goal[CSR_REF_CUBE]);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // One request, with an optional idle burst ahead of it
   task automatic send_byte(logic [7:0] data, logic last);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      sb.take_byte(data, last);
   endtask

   // Send unit_bytes; flag the final byte as last when close is set
   task automatic send_unit(bit close);
      foreach (unit_bytes[i])
         send_byte(unit_bytes[i], close && i == unit_bytes.size() - 1);
      units_sent++;
   endtask

   // Directed unit: given reference sums, bytes already in unit_bytes
   task automatic directed_unit(logic [SUM_W-1:0] p, logic [SUM_W-1:0] l,
                                logic [SUM_W-1:0] s, logic [SUM_W-1:0] c);
      wait_until_idle();
      ref_goal[CSR_REF_PLAIN] = p;
      ref_goal[CSR_REF_LINEAR] = l;
      ref_goal[CSR_REF_SQUARE] = s;
      ref_goal[CSR_REF_CUBE] = c;
      write_refs();
      send_unit(1'b1);
   endtask

   initial begin
      int len, pos, n_units, kind, cut;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= CSR_REF_PLAIN;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: clean unit straight after reset, then the delta extremes
      unit_bytes = {8'd0};
      send_unit(1'b1);
      unit_bytes = {8'd255};
      send_unit(1'b1);
      unit_bytes = {8'd0};
      directed_unit(32'd255, 32'd255, 32'd255, 32'd255);
      directed_unit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      directed_unit(32'd1, 32'd1, 32'd1, 32'd1);
      // sum of plain delta out of range in the negative direction
      directed_unit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // zero plain syndrome but cube syndrome nonzero
      directed_unit(32'd0, 32'd0, 32'd0, 32'd1);
      // error on the third byte
      unit_bytes = {8'd0, 8'd0, 8'd1};
      directed_unit(32'd0, 32'd0, 32'd0, 32'd0);
      // linear syndrome not a multiple of the delta
      unit_bytes = {8'd1, 8'd1};
      directed_unit(32'd0, 32'd0, 32'd0, 32'd0);
      // delta just past the byte range
      unit_bytes = {8'd128, 8'd128};
      directed_unit(32'd0, 32'd0, 32'd0, 32'd0);
      // position past the unit, then square and cube syndromes off
      unit_bytes = {8'd1, 8'd0};
      directed_unit(32'd0, 32'd1 - 32'd5, 32'd1 - 32'd25, 32'd1 - 32'd125);
      directed_unit(32'd0, 32'd1 - 32'd2, 32'd0, 32'd0);
      directed_unit(32'd0, 32'd1 - 32'd2, 32'd1 - 32'd4, 32'd0);
      // negative position
      unit_bytes = {8'd1};
      directed_unit(32'd0, 32'd2, 32'd0, 32'd0);

      // Random phases: program a pristine unit, send variants of it
      while (sb.bytes_taken < RANDOM_ITEMS) begin
         wait_until_idle();
         idle_enable = (sb.bytes_taken < (RANDOM_ITEMS * 4) / 5)
                       && $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 19))
            0: len = $urandom_range(100, 300);
            1, 2, 3, 4: len = $urandom_range(17, 64);
            default: len = $urandom_range(1, 16);
         endcase
         pristine.delete();
         repeat (len) pristine.push_back(pick_byte());
         load_ref_goal();
         // now and then the references are plain noise
         if ($urandom_range(0, 9) == 0)
            foreach (ref_goal[k]) ref_goal[k] = $urandom();
         write_refs();
         n_units = $urandom_range(1, 5);
         repeat (n_units) begin
            unit_bytes = pristine;
            kind = $urandom_range(0, 19);
            if (kind >= 6 && kind <= 15) begin
               // single corruption, a second one for some
               pos = $urandom_range(0, len - 1);
               unit_bytes[pos] = unit_bytes[pos] + 8'($urandom_range(1, 255));
               if (kind >= 14) begin
                  pos = $urandom_range(0, len - 1);
                  unit_bytes[pos] = unit_bytes[pos] + 8'($urandom_range(1, 255));
               end
            end else if (kind == 16 || kind == 17) begin
               unit_bytes.delete();
               repeat ($urandom_range(1, 24)) unit_bytes.push_back(pick_byte());
            end else if (kind == 18 && len > 1) begin
               cut = $urandom_range(1, len - 1);
               repeat (cut) void'(unit_bytes.pop_back());
            end else if (kind == 19) begin
               repeat ($urandom_range(1, 3)) unit_bytes.push_back(pick_byte());
            end
            send_unit(1'b1);
         end
      end

      // Drain and report
      idle_enable = 1'b0;
      wait_until_idle();
      $display("%0d bytes in %0d units; %0d reports: %0d clean, %0d located, %0d uncorrectable",
               sb.bytes_taken, units_sent, sb.reports_checked,
               sb.status_seen[STATUS_CLEAN], sb.status_seen[STATUS_LOCATED],
               sb.status_seen[STATUS_UNCORR]);
      $display("mismatches: %0d, reports still outstanding: %0d",
               sb.mismatch_count, sb.pending());
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/mcsef_pkg.sv
sv/mcsef_front.sv
sv/mcsef_queue.sv
sv/mcsef_back.sv
sv/moment_checksum_single_error_fix_unit.sv
tb/tb_top.sv
